[src/cts_pkg.sv]
// shared types and constants for the c token scanner
`timescale 1ns / 1ps
package cts_pkg;
  localparam int POSITION_BITS_DEF = 32;
  localparam int LENGTH_BITS_DEF   = 16;
  localparam int LINE_BITS         = 24;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  localparam logic [4:0] K_EOF      = 5'd0;
  localparam logic [4:0] K_IDENT    = 5'd1;
  localparam logic [4:0] K_NUMBER   = 5'd2;
  localparam logic [4:0] K_STRING   = 5'd3;
  localparam logic [4:0] K_CHAR     = 5'd4;
  localparam logic [4:0] K_SHL_EQ   = 5'd8;
  localparam logic [4:0] K_SHL      = 5'd9;
  localparam logic [4:0] K_SHR_EQ   = 5'd11;
  localparam logic [4:0] K_SHR      = 5'd12;
  localparam logic [4:0] K_ERROR    = 5'd26;

  localparam logic [7:0] CH_NL = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_EQ = 8'h3d;
  localparam logic [7:0] CH_US = 8'h5f;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR = 8'h2a;
  localparam logic [7:0] CH_LT = 8'h3c;
  localparam logic [7:0] CH_GT = 8'h3e;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction
  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction
  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic logic is_op_start(input logic [7:0] c);
    return c == 8'h26 || c == 8'h7c || c == CH_LT || c == CH_GT || c == CH_EQ ||
           c == 8'h21 || c == CH_STAR || c == CH_SLASH || c == 8'h25 || c == 8'h2b ||
           c == 8'h2d || c == 8'h5e || c == 8'h23;
  endfunction

  function automatic logic [4:0] pair_kind(input logic [7:0] f, input logic [7:0] c);
    logic [4:0] k;
    k = 5'd0;
    if (c == CH_EQ) begin
      case (f)
        CH_LT:    k = 5'd7;
        CH_GT:    k = 5'd10;
        CH_EQ:    k = 5'd13;
        8'h21:    k = 5'd14;
        CH_STAR:  k = 5'd15;
        CH_SLASH: k = 5'd16;
        8'h25:    k = 5'd17;
        8'h2b:    k = 5'd18;
        8'h2d:    k = 5'd19;
        8'h26:    k = 5'd20;
        8'h5e:    k = 5'd21;
        8'h7c:    k = 5'd22;
        default:  k = 5'd0;
      endcase
    end else if (c == f) begin
      case (f)
        8'h26:   k = 5'd5;
        8'h7c:   k = 5'd6;
        8'h2b:   k = 5'd23;
        8'h2d:   k = 5'd24;
        8'h23:   k = 5'd25;
        default: k = 5'd0;
      endcase
    end
    return k;
  endfunction

  // one token without position and length (widths set by parameters)
  typedef struct packed {
    logic [4:0]           kind;
    logic [7:0]           char_code;
    logic [LINE_BITS-1:0] line;
    logic                 at_line_start;
  } tok_info_t;
endpackage

[src/c_token_scanner.sv]
// top level of the c token scanner
//   channel | dir | tdata fields (low to high)                    | tuser / tlast
//   in_     | in  | text_byte                                      | tlast end_of_text
//   out_    | out | token_kind,char_code,token_start,token_length,  | tlast last
//           |     | line_number,at_line_start                      |
//   cfg_    | in  | newline token enable                           | -
// one byte word per cycle while in_tready is high; each byte yields up to three token words
// the scan state is registered on each accepted byte, tokens wait in an eight entry queue
// input stalls only when the queue cannot take three more tokens
// reset: rst_n synchronous active low, clears scan state, queue and newline token enable
`timescale 1ns / 1ps
module c_token_scanner import cts_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,  // text_byte
  input  logic       in_tlast,  // end_of_text
  output logic out_tvalid,
  input  logic out_tready,
  // token_kind, char_code, token_start, token_length, line_number, at_line_start
  output logic [((38+POSITION_BITS+LENGTH_BITS+7)/8)*8-1:0] out_tdata,
  output logic out_tlast,       // last
  input  logic cfg_we,
  input  logic cfg_wdata        // newline token enable
);
  localparam int OW = ((38+POSITION_BITS+LENGTH_BITS+7)/8)*8;

  logic                     keep_nl_r;
  logic                     step;
  logic [2:0]               tok_cnt;
  tok_info_t                tok_info [3];
  logic [POSITION_BITS-1:0] tok_start [3];
  logic [LENGTH_BITS-1:0]   tok_len [3];
  tok_info_t                o_info;
  logic [POSITION_BITS-1:0] o_start;
  logic [LENGTH_BITS-1:0]   o_len;

  always_ff @(posedge clk) begin
    if (!rst_n) keep_nl_r <= 1'b0;
    else if (cfg_we) keep_nl_r <= cfg_wdata;
  end

  assign step = in_tvalid && in_tready;

  cts_front #(.POSITION_BITS(POSITION_BITS), .LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk, .rst_n, .nl_tok_en(keep_nl_r), .step,
    .text_byte(in_tdata), .end_of_text(in_tlast),
    .tok_cnt, .tok_info, .tok_start, .tok_len
  );

  cts_back #(.POSITION_BITS(POSITION_BITS), .LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk, .rst_n, .push(step), .push_cnt(tok_cnt), .push_info(tok_info),
    .push_start(tok_start), .push_len(tok_len), .can_push(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_info(o_info),
    .out_start(o_start), .out_len(o_len), .out_last(out_tlast)
  );

  assign out_tdata = OW'({o_info.at_line_start, o_info.line, o_len, o_start,
                          o_info.char_code, o_info.kind});
endmodule

[src/cts_front.sv]
// front end: byte classification, scan state and token decisions
`timescale 1ns / 1ps
module cts_front import cts_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     nl_tok_en,
  input  logic                     step,
  input  logic [7:0]               text_byte,
  input  logic                     end_of_text,
  output logic [2:0]               tok_cnt,
  output tok_info_t                tok_info [3],
  output logic [POSITION_BITS-1:0] tok_start [3],
  output logic [LENGTH_BITS-1:0]   tok_len [3]
);
  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_LCOMMENT, M_BCOMMENT, M_BSTAR, M_OP1, M_OP2
  } mode_t;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;
  localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);

  mode_t                    mode_r, mode_nxt;
  logic [7:0]               pf_r, pf_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt, pos_r, pos_nxt;
  logic [LENGTH_BITS-1:0]   len_r, len_nxt;
  logic [LINE_BITS-1:0]     line_r, line_nxt;
  logic                     nls_r, nls_nxt;

  always_comb begin
    logic [4:0] k;
    logic       go_idle;
    logic       c_nl;
    c_nl = text_byte == CH_NL;
    mode_nxt = mode_r; pf_nxt = pf_r; start_nxt = start_r;
    len_nxt = len_r; line_nxt = line_r; nls_nxt = nls_r;
    tok_cnt = 3'd0;
    for (int i = 0; i < 3; i++) begin
      tok_info[i] = '0; tok_start[i] = '0; tok_len[i] = '0;
    end
    go_idle = 1'b0;
    k = pair_kind(pf_r, text_byte);

    unique case (mode_r)
      M_IDENT: begin
        if (is_alpha(text_byte) || is_digit(text_byte) || text_byte == CH_US) begin
          if (len_nxt != LEN_MAX) len_nxt = len_nxt + LEN_ONE;
        end else begin
          tok_info[0] = '{K_IDENT, 8'd0, line_nxt, nls_nxt};
          tok_start[0] = start_r; tok_len[0] = len_r; tok_cnt = 3'd1; nls_nxt = 1'b0;
          go_idle = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(text_byte) || text_byte == CH_DOT) begin
          if (len_nxt != LEN_MAX) len_nxt = len_nxt + LEN_ONE;
        end else begin
          tok_info[0] = '{K_NUMBER, 8'd0, line_nxt, nls_nxt};
          tok_start[0] = start_r; tok_len[0] = len_r; tok_cnt = 3'd1; nls_nxt = 1'b0;
          go_idle = 1'b1;
        end
      end
      M_STRING: begin
        if (len_nxt != LEN_MAX) len_nxt = len_nxt + LEN_ONE;
        if (c_nl && line_nxt != LINE_MAX) line_nxt = line_nxt + 1'b1;
        if (text_byte == CH_QUOTE) begin
          tok_info[0] = '{K_STRING, 8'd0, line_nxt, nls_nxt};
          tok_start[0] = start_r; tok_len[0] = len_nxt; tok_cnt = 3'd1; nls_nxt = 1'b0;
          mode_nxt = M_IDLE;
        end
      end
      M_LCOMMENT: begin
        if (!c_nl && text_byte != CH_CR) begin
          if (len_nxt != LEN_MAX) len_nxt = len_nxt + LEN_ONE;
        end else go_idle = 1'b1;
      end
      M_BCOMMENT, M_BSTAR: begin
        if (len_nxt != LEN_MAX) len_nxt = len_nxt + LEN_ONE;
        if (c_nl && line_nxt != LINE_MAX) line_nxt = line_nxt + 1'b1;
        if (mode_r == M_BSTAR && text_byte == CH_SLASH) mode_nxt = M_IDLE;
        else mode_nxt = (text_byte == CH_STAR) ? M_BSTAR : M_BCOMMENT;
      end
      M_OP1: begin
        if (pf_r == CH_SLASH && (text_byte == CH_SLASH || text_byte == CH_STAR)) begin
          if (len_nxt != LEN_MAX) len_nxt = len_nxt + LEN_ONE;
          mode_nxt = (text_byte == CH_SLASH) ? M_LCOMMENT : M_BCOMMENT;
        end else if ((pf_r == CH_LT || pf_r == CH_GT) && text_byte == pf_r) begin
          if (len_nxt != LEN_MAX) len_nxt = len_nxt + LEN_ONE;
          mode_nxt = M_OP2;
        end else if (k != 5'd0) begin
          if (len_nxt != LEN_MAX) len_nxt = len_nxt + LEN_ONE;
          tok_info[0] = '{k, 8'd0, line_nxt, nls_nxt};
          tok_start[0] = start_r; tok_len[0] = len_nxt; tok_cnt = 3'd1; nls_nxt = 1'b0;
          mode_nxt = M_IDLE;
        end else begin
          tok_info[0] = '{K_CHAR, pf_r, line_nxt, nls_nxt};
          tok_start[0] = start_r; tok_len[0] = len_r; tok_cnt = 3'd1; nls_nxt = 1'b0;
          go_idle = 1'b1;
        end
      end
      M_OP2: begin
        if (text_byte == CH_EQ) begin
          if (len_nxt != LEN_MAX) len_nxt = len_nxt + LEN_ONE;
          tok_info[0] = '{(pf_r == CH_LT) ? K_SHL_EQ : K_SHR_EQ, 8'd0, line_nxt, nls_nxt};
          tok_start[0] = start_r; tok_len[0] = len_nxt; tok_cnt = 3'd1; nls_nxt = 1'b0;
          mode_nxt = M_IDLE;
        end else begin
          tok_info[0] = '{(pf_r == CH_LT) ? K_SHL : K_SHR, 8'd0, line_nxt, nls_nxt};
          tok_start[0] = start_r; tok_len[0] = len_r; tok_cnt = 3'd1; nls_nxt = 1'b0;
          go_idle = 1'b1;
        end
      end
      default: go_idle = 1'b1;
    endcase

    if (go_idle) begin
      mode_nxt = M_IDLE; start_nxt = pos_r; len_nxt = LEN_ONE;
      if (is_space(text_byte)) begin
        if (c_nl) begin
          if (line_nxt != LINE_MAX) line_nxt = line_nxt + 1'b1;
          if (nl_tok_en) begin
            tok_info[tok_cnt[1:0]] = '{K_CHAR, text_byte, line_nxt, nls_nxt};
            tok_start[tok_cnt[1:0]] = pos_r; tok_len[tok_cnt[1:0]] = LEN_ONE;
            tok_cnt = tok_cnt + 3'd1;
          end
          nls_nxt = 1'b1;
        end
      end else if (is_alpha(text_byte) || text_byte == CH_US) mode_nxt = M_IDENT;
      else if (is_digit(text_byte)) mode_nxt = M_NUMBER;
      else if (text_byte == CH_QUOTE) mode_nxt = M_STRING;
      else if (is_op_start(text_byte)) begin
        mode_nxt = M_OP1; pf_nxt = text_byte;
      end else begin
        tok_info[tok_cnt[1:0]] = '{K_CHAR, text_byte, line_nxt, nls_nxt};
        tok_start[tok_cnt[1:0]] = pos_r; tok_len[tok_cnt[1:0]] = LEN_ONE;
        tok_cnt = tok_cnt + 3'd1; nls_nxt = 1'b0;
      end
    end

    pos_nxt = (pos_r != POS_MAX) ? pos_r + 1'b1 : pos_r;

    if (end_of_text) begin
      if (mode_nxt != M_IDLE && mode_nxt != M_LCOMMENT) begin
        tok_start[tok_cnt[1:0]] = start_nxt; tok_len[tok_cnt[1:0]] = len_nxt;
        tok_info[tok_cnt[1:0]].line = line_nxt;
        tok_info[tok_cnt[1:0]].at_line_start = nls_nxt;
        tok_info[tok_cnt[1:0]].char_code = 8'd0;
        case (mode_nxt)
          M_IDENT:  tok_info[tok_cnt[1:0]].kind = K_IDENT;
          M_NUMBER: tok_info[tok_cnt[1:0]].kind = K_NUMBER;
          M_OP1: begin
            tok_info[tok_cnt[1:0]].kind = K_CHAR;
            tok_info[tok_cnt[1:0]].char_code = pf_nxt;
          end
          M_OP2: tok_info[tok_cnt[1:0]].kind = (pf_nxt == CH_LT) ? K_SHL : K_SHR;
          default: tok_info[tok_cnt[1:0]].kind = K_ERROR;
        endcase
        tok_cnt = tok_cnt + 3'd1; nls_nxt = 1'b0;
      end
      tok_info[tok_cnt[1:0]] = '{K_EOF, 8'd0, line_nxt, nls_nxt};
      tok_start[tok_cnt[1:0]] = pos_nxt; tok_len[tok_cnt[1:0]] = '0;
      tok_cnt = tok_cnt + 3'd1;
      mode_nxt = M_IDLE; pf_nxt = '0; start_nxt = '0; pos_nxt = '0;
      len_nxt = '0; line_nxt = LINE_BITS'(1); nls_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; pf_r <= '0; start_r <= '0; pos_r <= '0;
      len_r <= '0; line_r <= LINE_BITS'(1); nls_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt; pf_r <= pf_nxt; start_r <= start_nxt; pos_r <= pos_nxt;
      len_r <= len_nxt; line_r <= line_nxt; nls_r <= nls_nxt;
    end
  end
endmodule

[src/cts_back.sv]
// back end: token queue and serialization onto the result stream
`timescale 1ns / 1ps
module cts_back import cts_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [2:0]               push_cnt,
  input  tok_info_t                push_info [3],
  input  logic [POSITION_BITS-1:0] push_start [3],
  input  logic [LENGTH_BITS-1:0]   push_len [3],
  output logic                     can_push,
  output logic                     out_valid,
  input  logic                     out_ready,
  output tok_info_t                out_info,
  output logic [POSITION_BITS-1:0] out_start,
  output logic [LENGTH_BITS-1:0]   out_len,
  output logic                     out_last
);
  // 8 entry ring of tokens; last flag marks final token of a byte
  localparam int DEPTH = 8;
  localparam int AW = $clog2(DEPTH);

  tok_info_t                q_info_r  [DEPTH];
  logic [POSITION_BITS-1:0] q_start_r [DEPTH];
  logic [LENGTH_BITS-1:0]   q_len_r   [DEPTH];
  logic                     q_last_r  [DEPTH];
  logic [AW-1:0]            wp_r, rp_r;
  logic [AW:0]              cnt_r, cnt_nxt;
  logic                     pop;

  assign can_push  = cnt_r <= (AW+1)'(DEPTH - 3);
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && out_ready;
  assign out_info  = q_info_r[rp_r];
  assign out_start = q_start_r[rp_r];
  assign out_len   = q_len_r[rp_r];
  assign out_last  = q_last_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r - (AW+1)'(pop);
    if (push) cnt_nxt = cnt_nxt + (AW+1)'(push_cnt);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < 3; i++) begin
        if (3'(i) < push_cnt) begin
          q_info_r[wp_r + AW'(i)]  <= push_info[i];
          q_start_r[wp_r + AW'(i)] <= push_start[i];
          q_len_r[wp_r + AW'(i)]   <= push_len[i];
          q_last_r[wp_r + AW'(i)]  <= 3'(i) == push_cnt - 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + AW'(push_cnt);
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

[tb/tb_c_token_scanner.sv]
// self-checking testbench for the c token scanner with a token scoreboard
`timescale 1ns / 1ps
module tb_c_token_scanner;
  import cts_pkg::*;

  localparam int PB = POSITION_BITS_DEF;
  localparam int LB = LENGTH_BITS_DEF;
  localparam int OUT_W = ((38 + PB + LB + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int OP_BASE = 5;

  typedef enum logic [3:0] {
    SM_IDLE, SM_IDENT, SM_NUMBER, SM_STRING, SM_LCOMMENT, SM_BCOMMENT, SM_BSTAR,
    SM_OP1, SM_OP2
  } scan_mode_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  char_code;
    logic [PB-1:0] start;
    logic [LB-1:0] length;
    logic [LINE_BITS-1:0] line;
    logic nl_flag;
    logic last;
  } token_t;

  class token_scoreboard;
    string op_names[21] = '{"&&", "||", "<=", "<<=", "<<", ">=", ">>=", ">>", "==", "!=",
                           "*=", "/=", "%=", "+=", "-=", "&=", "^=", "|=", "++", "--",
                           "##"};
    token_t expected_tokens[$];
    token_t step_tokens[$];
    bit keep_nl;
    scan_mode_t mode;
    logic [7:0] first_ch;
    logic [PB-1:0] span_pos, byte_pos;
    logic [LB-1:0] span_len;
    logic [LINE_BITS-1:0] lines;
    bit nl_seen;
    int mismatches, tokens_seen, bytes_seen;

    function void clear();
      mode = SM_IDLE; first_ch = 0; span_pos = 0; byte_pos = 0; span_len = 0;
      lines = 1; nl_seen = 0;
    endfunction

    function void reset_all();
      keep_nl = 0;
      clear();
    endfunction

    function bit alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction
    function bit space(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function bit op_start(logic [7:0] c);
      string s;
      s = "&|<>=!*/%+-^#";
      foreach (s[i]) if (s[i] == c) return 1;
      return 0;
    endfunction

    function logic [4:0] two_char_kind(logic [7:0] f, logic [7:0] c);
      string p;
      p = "  ";
      p[0] = f;
      p[1] = c;
      foreach (op_names[i]) if (op_names[i] == p) return 5'(OP_BASE + i);
      return K_EOF;
    endfunction

    function void bump_line();
      if (lines != LINE_MAX) lines++;
    endfunction
    function void grow();
      if (span_len != '1) span_len++;
    endfunction

    function void emit(logic [4:0] k, logic [7:0] ch, logic [PB-1:0] st, logic [LB-1:0] ln);
      token_t t;
      t.kind = k; t.char_code = ch; t.start = st; t.length = ln;
      t.line = lines; t.nl_flag = nl_seen; t.last = 0;
      nl_seen = 0;
      step_tokens = {step_tokens, t};
    endfunction

    function void fresh_byte(logic [7:0] c, logic [PB-1:0] pos);
      mode = SM_IDLE;
      span_pos = pos;
      span_len = 1;
      if (space(c)) begin
        if (c == CH_NL) begin
          bump_line();
          if (keep_nl) emit(K_CHAR, c, pos, 1);
          nl_seen = 1;
        end
      end else if (alpha(c) || c == CH_US) begin
        mode = SM_IDENT;
      end else if (digit(c)) begin
        mode = SM_NUMBER;
      end else if (c == CH_QUOTE) begin
        mode = SM_STRING;
      end else if (op_start(c)) begin
        mode = SM_OP1;
        first_ch = c;
      end else begin
        emit(K_CHAR, c, pos, 1);
      end
    endfunction

    // returns 1 when the byte also starts a fresh token
    function bit scan(logic [7:0] c);
      logic [4:0] k;
      case (mode)
        SM_IDENT: begin
          if (alpha(c) || digit(c) || c == CH_US) begin grow(); return 0; end
          emit(K_IDENT, 0, span_pos, span_len);
        end
        SM_NUMBER: begin
          if (digit(c) || c == CH_DOT) begin grow(); return 0; end
          emit(K_NUMBER, 0, span_pos, span_len);
        end
        SM_STRING: begin
          grow();
          if (c == CH_NL) bump_line();
          if (c == CH_QUOTE) begin
            emit(K_STRING, 0, span_pos, span_len);
            mode = SM_IDLE;
          end
          return 0;
        end
        SM_LCOMMENT: begin
          if (c != CH_NL && c != CH_CR) begin grow(); return 0; end
        end
        SM_BCOMMENT, SM_BSTAR: begin
          grow();
          if (c == CH_NL) bump_line();
          if (mode == SM_BSTAR && c == CH_SLASH) mode = SM_IDLE;
          else mode = (c == CH_STAR) ? SM_BSTAR : SM_BCOMMENT;
          return 0;
        end
        SM_OP1: begin
          if (first_ch == CH_SLASH && (c == CH_SLASH || c == CH_STAR)) begin
            grow();
            mode = (c == CH_SLASH) ? SM_LCOMMENT : SM_BCOMMENT;
            return 0;
          end
          if ((first_ch == CH_LT || first_ch == CH_GT) && c == first_ch) begin
            grow();
            mode = SM_OP2;
            return 0;
          end
          k = two_char_kind(first_ch, c);
          if (k != K_EOF) begin
            grow();
            emit(k, 0, span_pos, span_len);
            mode = SM_IDLE;
            return 0;
          end
          emit(K_CHAR, first_ch, span_pos, span_len);
        end
        SM_OP2: begin
          if (c == CH_EQ) begin
            grow();
            emit(first_ch == CH_LT ? K_SHL_EQ : K_SHR_EQ, 0, span_pos, span_len);
            mode = SM_IDLE;
            return 0;
          end
          emit(first_ch == CH_LT ? K_SHL : K_SHR, 0, span_pos, span_len);
        end
        default: ;
      endcase
      return 1;
    endfunction

    function void note_byte(logic [7:0] c, logic eot);
      logic [PB-1:0] pos;
      pos = byte_pos;
      bytes_seen++;
      step_tokens.delete();
      if (scan(c)) fresh_byte(c, pos);
      if (byte_pos != '1) byte_pos++;
      if (eot) begin
        case (mode)
          SM_IDENT: emit(K_IDENT, 0, span_pos, span_len);
          SM_NUMBER: emit(K_NUMBER, 0, span_pos, span_len);
          SM_STRING, SM_BCOMMENT, SM_BSTAR: emit(K_ERROR, 0, span_pos, span_len);
          SM_OP1: emit(K_CHAR, first_ch, span_pos, span_len);
          SM_OP2: emit(first_ch == CH_LT ? K_SHL : K_SHR, 0, span_pos, span_len);
          default: ;
        endcase
        emit(K_EOF, 0, byte_pos, 0);
        clear();
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1;
      expected_tokens = {expected_tokens, step_tokens};
    endfunction

    function void check_token(logic [OUT_W-1:0] d, logic lst);
      token_t e, a;
      a.kind = d[4:0];
      a.char_code = d[12:5];
      a.start = d[13 +: PB];
      a.length = d[13 + PB +: LB];
      a.line = d[13 + PB + LB +: LINE_BITS];
      a.nl_flag = d[13 + PB + LB + LINE_BITS];
      a.last = lst;
      tokens_seen++;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token word: kind %0d start %0d",
                                       a.kind, a.start);
        return;
      end
      e = expected_tokens.pop_front();
      if (a != e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("token mismatch exp k%0d c%0d s%0d l%0d ln%0d n%0d t%0d",
                   e.kind, e.char_code, e.start, e.length, e.line, e.nl_flag, e.last,
                   " got k%0d c%0d s%0d l%0d ln%0d n%0d t%0d",
                   a.kind, a.char_code, a.start, a.length, a.line, a.nl_flag, a.last);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [7:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we, cfg_wdata;

  token_scoreboard sb;
  int send_idle_pct, recv_stall_pct, texts_sent;
  int unsigned cycles;

  c_token_scanner uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // token side: check words and stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_token(out_tdata, out_tlast);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_byte(logic [7:0] b, logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= b;
    in_tlast <= eot;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, eot);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i], i == s.len() - 1);
    texts_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_keep_nl(bit v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.keep_nl = v;
  endtask

  function automatic string word_from(string set, int n);
    string s;
    s = "";
    repeat (n) s = {s, string'(set[$urandom_range(set.len() - 1)])};
    return s;
  endfunction

  function automatic string random_piece();
    string al, s;
    byte b;
    al = "abcxyzQZ_09";
    case ($urandom_range(11))
      0: s = {word_from("aZ_q", 1), word_from(al, $urandom_range(5))};
      1: s = {word_from("0579", 1), word_from("12.9", $urandom_range(4))};
      2: s = {"\"", word_from("ab \n*/", $urandom_range(5)), "\""};
      3, 4: s = sb.op_names[$urandom_range(20)];
      5: s = word_from("&|<>=!*/%+-^#", 1);
      6: s = word_from(" \t\r\v\f", 1);
      7: s = "\n";
      8: s = {"//", word_from("ab */", $urandom_range(4)), word_from("\n\r", 1)};
      9: s = {"/*", word_from("a*/\n", $urandom_range(5)), "*/"};
      10: begin
        b = byte'($urandom_range(255));
        s = " ";
        s[0] = b;
      end
      default: s = word_from("();,{}[]@$.~?", 1);
    endcase
    return s;
  endfunction

  task automatic random_phase(int idle, int stall, int nbytes);
    string t;
    int count;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    count = 0;
    while (count < nbytes) begin
      t = "";
      repeat ($urandom_range(1, 8)) t = {t, random_piece()};
      case ($urandom_range(9))
        0: t = {t, "\"ab"};
        1: t = {t, "/*x*"};
        2: t = {t, "//e"};
        default: ;
      endcase
      count += t.len();
      send_text(t);
      if (count > nbytes / 2 && count - t.len() <= nbytes / 2) begin
        // hold off until every token is out
        in_tvalid <= 0;
        while (sb.expected_tokens.size() != 0) @(posedge clk);
      end
    end
    drain();
  endtask

  initial begin
    sb = new();
    sb.reset_all();
    cycles = 0;
    rst_n = 0;
    in_tvalid = 0; in_tdata = 0; in_tlast = 0;
    out_tready = 0; cfg_we = 0; cfg_wdata = 0;
    send_idle_pct = 0; recv_stall_pct = 0; texts_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_keep_nl(1);
    send_text("x_9<<=1.2;\n");
    send_text("/*a*/\"s");
    send_text(">>a//c\r");
    send_byte(8'hff, 0);
    send_byte(8'h00, 1);
    drain();

    write_keep_nl(0);
    random_phase(0, 0, 85);
    write_keep_nl(1);
    random_phase(78, 0, 85);
    write_keep_nl(0);
    random_phase(0, 78, 85);
    write_keep_nl(1);
    random_phase(36, 36, 85);

    $display("scanned %0d bytes in %0d texts, checked %0d tokens,",
             sb.bytes_seen, texts_sent, sb.tokens_seen);
    $display("both newline settings under four idle and stall mixes, %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_tokens.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
